// ----- rtl/srlf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srlf_pkg
// shared types, sizes and codes of the per-source rate limit filter
// ----------------------------------------------------------------------------
package srlf_pkg;

   localparam int ALLOW_ENTRIES    = 256;
   localparam int LOG_BAN_ENTRIES  = 1024;
   localparam int RATE_BAN_ENTRIES = 1024;
   localparam int COUNTER_ENTRIES  = 2048;

   localparam int ALLOW_AW   = (ALLOW_ENTRIES > 1) ? $clog2(ALLOW_ENTRIES) : 1;
   localparam int LOG_AW     = (LOG_BAN_ENTRIES > 1) ? $clog2(LOG_BAN_ENTRIES) : 1;
   localparam int RATE_AW    = (RATE_BAN_ENTRIES > 1) ? $clog2(RATE_BAN_ENTRIES) : 1;
   localparam int COUNTER_AW = (COUNTER_ENTRIES > 1) ? $clog2(COUNTER_ENTRIES) : 1;

   localparam int MAX_AB = (ALLOW_ENTRIES > LOG_BAN_ENTRIES) ? ALLOW_ENTRIES : LOG_BAN_ENTRIES;
   localparam int MAX_RC = (RATE_BAN_ENTRIES > COUNTER_ENTRIES) ?
                           RATE_BAN_ENTRIES : COUNTER_ENTRIES;
   localparam int SCAN_ENTRIES = (MAX_AB > MAX_RC) ? MAX_AB : MAX_RC;
   localparam int SCAN_W       = $clog2(SCAN_ENTRIES + 1);

   localparam int COUNT_W = 17;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   localparam logic [15:0] THRESHOLD_RESET = 16'd50;
   localparam logic [63:0] WINDOW_RESET    = 64'd1000000000;
   localparam logic [63:0] BAN_RESET       = 64'd1800000000000;

   localparam logic [2:0] KIND_PACKET    = 3'd0;
   localparam logic [2:0] KIND_ALLOW_ADD = 3'd1;
   localparam logic [2:0] KIND_ALLOW_DEL = 3'd2;
   localparam logic [2:0] KIND_LOG_SET   = 3'd3;
   localparam logic [2:0] KIND_LOG_CLR   = 3'd4;

   localparam logic [1:0] REG_THRESHOLD = 2'd0;
   localparam logic [1:0] REG_WINDOW    = 2'd1;
   localparam logic [1:0] REG_BAN       = 2'd2;

   typedef enum logic [2:0] {
      OP_PACKET    = 3'd0,
      OP_ALLOW_ADD = 3'd1,
      OP_ALLOW_DEL = 3'd2,
      OP_LOG_SET   = 3'd3,
      OP_LOG_CLR   = 3'd4,
      OP_NOP       = 3'd5,
      OP_NOT_IPV4  = 3'd6
   } op_type;

   typedef enum logic [2:0] {
      CAUSE_NOT_IPV4  = 3'd0,
      CAUSE_ALLOWED   = 3'd1,
      CAUSE_LOG_BAN   = 3'd2,
      CAUSE_ACK_ONLY  = 3'd3,
      CAUSE_RATE_BAN  = 3'd4,
      CAUSE_NEW_BAN   = 3'd5,
      CAUSE_COUNTED   = 3'd6,
      CAUSE_CONTROL   = 3'd7
   } cause_type;

   typedef struct packed {
      op_type      op;
      logic [31:0] ip;
      logic        ack_only;
      logic [63:0] now;
      logic [63:0] ban_end;
   } item_type;

   typedef struct packed {
      logic [15:0] threshold;
      logic [63:0] window;
      logic [63:0] ban;
   } cfg_type;

   typedef struct packed {
      logic clearing;
   } status_type;

   typedef struct packed {
      logic        valid;
      logic [31:0] key;
   } allow_row_type;

   typedef struct packed {
      logic        valid;
      logic [31:0] key;
      logic [63:0] expiry;
   } ban_row_type;

   typedef struct packed {
      logic               valid;
      logic [31:0]        key;
      logic [63:0]        start;
      logic [COUNT_W-1:0] count;
   } ctr_row_type;

endpackage

// ----- rtl/per_source_rate_limit_filter_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_source_rate_limit_filter_core
// per-source fixed-window packet rate limiter with allow list and bans
// ----------------------------------------------------------------------------
// Each request word (a packet or a table control operation) gives exactly one
// response word. The four tables are fully associative and live in memories
// that are scanned together, one entry per cycle through their read ports, for
// every packet or control word; non-IPv4 packets and unknown kinds skip the scan.
// A two-word queue sits in front of the table engine and the response has its
// own output register. After reset a clearing pass over all SCAN_ENTRIES
// addresses empties the tables; no request is taken until it ends, while
// configuration writes are accepted at any time.
module per_source_rate_limit_filter_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_wdata,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_kind,
   input  logic [31:0] req_src_ip,
   input  logic        req_is_ipv4,
   input  logic        req_tcp_header_ok,
   input  logic        req_tcp_ack,
   input  logic        req_tcp_syn,
   input  logic [63:0] req_now_ns,
   input  logic [63:0] req_ban_until_ns,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_verdict,
   output logic [2:0]  rsp_cause,
   output logic        rsp_insert_failed
);
   import srlf_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   status_type status;
   item_type   push_item, head;
   logic       push, pop, full, not_empty;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            REG_THRESHOLD: cfg_in.threshold = csr_wdata[15:0];
            REG_WINDOW:    cfg_in.window    = csr_wdata;
            REG_BAN:       cfg_in.ban       = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.threshold <= THRESHOLD_RESET;
         cfg_ff.window    <= WINDOW_RESET;
         cfg_ff.ban       <= BAN_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_stall = full || status.clearing;

   srlf_front u_front (
      .req_valid(req_valid), .req_stall(req_stall), .req_kind(req_kind),
      .req_src_ip(req_src_ip), .req_is_ipv4(req_is_ipv4),
      .req_tcp_header_ok(req_tcp_header_ok), .req_tcp_ack(req_tcp_ack),
      .req_tcp_syn(req_tcp_syn), .req_now_ns(req_now_ns),
      .req_ban_until_ns(req_ban_until_ns), .push(push), .item(push_item));

   srlf_fifo u_fifo (
      .clock(clock), .reset(reset), .push(push), .push_item(push_item),
      .pop(pop), .full(full), .not_empty(not_empty), .head(head));

   srlf_back u_back (
      .clock(clock), .reset(reset), .cfg(cfg_ff), .q_valid(not_empty),
      .q_item(head), .q_pop(pop), .status(status), .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall), .rsp_verdict(rsp_verdict), .rsp_cause(rsp_cause),
      .rsp_insert_failed(rsp_insert_failed));

endmodule

// ----- rtl/srlf_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srlf_ram
// simple dual port memory, one write and one registered read
// ----------------------------------------------------------------------------
module srlf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/srlf_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srlf_front
// takes request words and classifies them for the table engine
// ----------------------------------------------------------------------------
module srlf_front (
   input  logic             req_valid,
   input  logic             req_stall,
   input  logic [2:0]       req_kind,
   input  logic [31:0]      req_src_ip,
   input  logic             req_is_ipv4,
   input  logic             req_tcp_header_ok,
   input  logic             req_tcp_ack,
   input  logic             req_tcp_syn,
   input  logic [63:0]      req_now_ns,
   input  logic [63:0]      req_ban_until_ns,
   output logic             push,
   output srlf_pkg::item_type item
);
   import srlf_pkg::*;

   op_type op;

   always_comb begin
      case (req_kind)
         KIND_PACKET:    op = req_is_ipv4 ? OP_PACKET : OP_NOT_IPV4;
         KIND_ALLOW_ADD: op = OP_ALLOW_ADD;
         KIND_ALLOW_DEL: op = OP_ALLOW_DEL;
         KIND_LOG_SET:   op = OP_LOG_SET;
         KIND_LOG_CLR:   op = OP_LOG_CLR;
         default:        op = OP_NOP;
      endcase
   end

   assign push          = req_valid && !req_stall;
   assign item.op       = op;
   assign item.ip       = req_src_ip;
   assign item.ack_only = req_tcp_header_ok && req_tcp_ack && !req_tcp_syn;
   assign item.now      = req_now_ns;
   assign item.ban_end  = req_ban_until_ns;

endmodule

// ----- rtl/srlf_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srlf_fifo
// two-entry queue between the classifier and the table engine
// ----------------------------------------------------------------------------
module srlf_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  srlf_pkg::item_type push_item,
   input  logic              pop,
   output logic              full,
   output logic              not_empty,
   output srlf_pkg::item_type head
);
   import srlf_pkg::*;

   item_type   slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign head      = slot_ff[rd_ptr_ff];

endmodule

// ----- rtl/srlf_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srlf_back
// table engine: scans all four tables in step, decides, writes back
// ----------------------------------------------------------------------------
module srlf_back (
   input  logic               clock,
   input  logic               reset,
   input  srlf_pkg::cfg_type  cfg,
   input  logic               q_valid,
   input  srlf_pkg::item_type q_item,
   output logic               q_pop,
   output srlf_pkg::status_type status,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_verdict,
   output logic [2:0]         rsp_cause,
   output logic               rsp_insert_failed
);
   import srlf_pkg::*;

   typedef enum logic [7:0] {
      ST_CLEAR = 8'b0000_0001,
      ST_IDLE  = 8'b0000_0010,
      ST_SCAN  = 8'b0000_0100,
      ST_DEC1  = 8'b0000_1000,
      ST_DEC2  = 8'b0001_0000,
      ST_WR    = 8'b0010_0000,
      ST_WR2   = 8'b0100_0000,
      ST_DONE  = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   logic [SCAN_W-1:0] scan_ff, scan_in;
   logic [SCAN_W-1:0] sd_ff, sd_in;
   logic live_ff, live_in;
   item_type cur_ff, cur_in;

   // scan results
   logic a_found_ff, a_found_in, a_free_ok_ff, a_free_ok_in;
   logic [ALLOW_AW-1:0] a_fidx_ff, a_fidx_in, a_free_ff, a_free_in;
   logic l_found_ff, l_found_in, l_free_ok_ff, l_free_ok_in;
   logic [LOG_AW-1:0] l_fidx_ff, l_fidx_in, l_free_ff, l_free_in;
   logic [63:0] l_exp_ff, l_exp_in;
   logic r_found_ff, r_found_in, r_free_ok_ff, r_free_ok_in;
   logic [RATE_AW-1:0] r_fidx_ff, r_fidx_in, r_free_ff, r_free_in;
   logic [63:0] r_exp_ff, r_exp_in;
   logic c_found_ff, c_found_in, c_free_ok_ff, c_free_ok_in;
   logic [COUNTER_AW-1:0] c_fidx_ff, c_fidx_in, c_free_ff, c_free_in;
   logic [63:0] c_start_ff, c_start_in;
   logic [COUNT_W-1:0] c_count_ff, c_count_in;

   // first decision stage
   logic l_live_ff, l_live_in, r_live_ff, r_live_in, in_win_ff, in_win_in;
   logic [COUNT_W-1:0] cnt_next_ff, cnt_next_in;
   logic [63:0] ban_exp_ff, ban_exp_in;

   // write commands
   logic a_we_ff, a_we_in;
   logic [ALLOW_AW-1:0] a_wa_ff, a_wa_in;
   allow_row_type a_wd_ff, a_wd_in;
   logic l_we_ff, l_we_in;
   logic [LOG_AW-1:0] l_wa_ff, l_wa_in;
   ban_row_type l_wd_ff, l_wd_in;
   logic r_we_ff, r_we_in;
   logic [RATE_AW-1:0] r_wa_ff, r_wa_in;
   ban_row_type r_wd_ff, r_wd_in;
   logic r2_we_ff, r2_we_in;
   logic [RATE_AW-1:0] r2_wa_ff, r2_wa_in;
   ban_row_type r2_wd_ff, r2_wd_in;
   logic c_we_ff, c_we_in;
   logic [COUNTER_AW-1:0] c_wa_ff, c_wa_in;
   ctr_row_type c_wd_ff, c_wd_in;

   // result
   logic res_verdict_ff, res_verdict_in, res_failed_ff, res_failed_in;
   cause_type res_cause_ff, res_cause_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_verdict_ff, rsp_verdict_in, rsp_failed_ff, rsp_failed_in;
   cause_type rsp_cause_ff, rsp_cause_in;

   // memory ports
   logic a_mwe, l_mwe, r_mwe, c_mwe;
   logic [ALLOW_AW-1:0] a_mwa;
   logic [LOG_AW-1:0] l_mwa;
   logic [RATE_AW-1:0] r_mwa;
   logic [COUNTER_AW-1:0] c_mwa;
   allow_row_type a_mwd, a_rd;
   ban_row_type l_mwd, l_rd, r_mwd, r_rd;
   ctr_row_type c_mwd, c_rd;
   logic [$bits(allow_row_type)-1:0] a_rd_raw;
   logic [$bits(ban_row_type)-1:0] l_rd_raw, r_rd_raw;
   logic [$bits(ctr_row_type)-1:0] c_rd_raw;

   assign a_rd = allow_row_type'(a_rd_raw);
   assign l_rd = ban_row_type'(l_rd_raw);
   assign r_rd = ban_row_type'(r_rd_raw);
   assign c_rd = ctr_row_type'(c_rd_raw);

   srlf_ram #(.WIDTH($bits(allow_row_type)), .DEPTH(ALLOW_ENTRIES)) u_allow (
      .clock(clock), .wr_en(a_mwe), .wr_addr(a_mwa), .wr_data(a_mwd),
      .rd_addr(scan_ff[ALLOW_AW-1:0]), .rd_data(a_rd_raw));
   srlf_ram #(.WIDTH($bits(ban_row_type)), .DEPTH(LOG_BAN_ENTRIES)) u_log (
      .clock(clock), .wr_en(l_mwe), .wr_addr(l_mwa), .wr_data(l_mwd),
      .rd_addr(scan_ff[LOG_AW-1:0]), .rd_data(l_rd_raw));
   srlf_ram #(.WIDTH($bits(ban_row_type)), .DEPTH(RATE_BAN_ENTRIES)) u_rate (
      .clock(clock), .wr_en(r_mwe), .wr_addr(r_mwa), .wr_data(r_mwd),
      .rd_addr(scan_ff[RATE_AW-1:0]), .rd_data(r_rd_raw));
   srlf_ram #(.WIDTH($bits(ctr_row_type)), .DEPTH(COUNTER_ENTRIES)) u_ctr (
      .clock(clock), .wr_en(c_mwe), .wr_addr(c_mwa), .wr_data(c_mwd),
      .rd_addr(scan_ff[COUNTER_AW-1:0]), .rd_data(c_rd_raw));

   // memory write selection
   always_comb begin
      a_mwe = 1'b0;
      l_mwe = 1'b0;
      r_mwe = 1'b0;
      c_mwe = 1'b0;
      a_mwa = a_wa_ff;
      l_mwa = l_wa_ff;
      r_mwa = r_wa_ff;
      c_mwa = c_wa_ff;
      a_mwd = a_wd_ff;
      l_mwd = l_wd_ff;
      r_mwd = r_wd_ff;
      c_mwd = c_wd_ff;
      case (state_ff)
         ST_CLEAR: begin
            a_mwe = scan_ff < SCAN_W'(ALLOW_ENTRIES);
            l_mwe = scan_ff < SCAN_W'(LOG_BAN_ENTRIES);
            r_mwe = scan_ff < SCAN_W'(RATE_BAN_ENTRIES);
            c_mwe = scan_ff < SCAN_W'(COUNTER_ENTRIES);
            a_mwa = scan_ff[ALLOW_AW-1:0];
            l_mwa = scan_ff[LOG_AW-1:0];
            r_mwa = scan_ff[RATE_AW-1:0];
            c_mwa = scan_ff[COUNTER_AW-1:0];
            a_mwd = '0;
            l_mwd = '0;
            r_mwd = '0;
            c_mwd = '0;
         end
         ST_WR: begin
            a_mwe = a_we_ff;
            l_mwe = l_we_ff;
            r_mwe = r_we_ff;
            c_mwe = c_we_ff;
         end
         ST_WR2: begin
            r_mwe = r2_we_ff;
            r_mwa = r2_wa_ff;
            r_mwd = r2_wd_ff;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      scan_in  = scan_ff;
      sd_in    = sd_ff;
      live_in  = 1'b0;
      cur_in   = cur_ff;
      q_pop    = 1'b0;

      a_found_in = a_found_ff; a_free_ok_in = a_free_ok_ff;
      a_fidx_in  = a_fidx_ff;  a_free_in    = a_free_ff;
      l_found_in = l_found_ff; l_free_ok_in = l_free_ok_ff;
      l_fidx_in  = l_fidx_ff;  l_free_in    = l_free_ff;  l_exp_in = l_exp_ff;
      r_found_in = r_found_ff; r_free_ok_in = r_free_ok_ff;
      r_fidx_in  = r_fidx_ff;  r_free_in    = r_free_ff;  r_exp_in = r_exp_ff;
      c_found_in = c_found_ff; c_free_ok_in = c_free_ok_ff;
      c_fidx_in  = c_fidx_ff;  c_free_in    = c_free_ff;
      c_start_in = c_start_ff; c_count_in   = c_count_ff;

      l_live_in   = l_live_ff;
      r_live_in   = r_live_ff;
      in_win_in   = in_win_ff;
      cnt_next_in = cnt_next_ff;
      ban_exp_in  = ban_exp_ff;

      a_we_in = a_we_ff; a_wa_in = a_wa_ff; a_wd_in = a_wd_ff;
      l_we_in = l_we_ff; l_wa_in = l_wa_ff; l_wd_in = l_wd_ff;
      r_we_in = r_we_ff; r_wa_in = r_wa_ff; r_wd_in = r_wd_ff;
      r2_we_in = r2_we_ff; r2_wa_in = r2_wa_ff; r2_wd_in = r2_wd_ff;
      c_we_in = c_we_ff; c_wa_in = c_wa_ff; c_wd_in = c_wd_ff;

      res_verdict_in = res_verdict_ff;
      res_cause_in   = res_cause_ff;
      res_failed_in  = res_failed_ff;

      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_verdict_in = rsp_verdict_ff;
      rsp_cause_in   = rsp_cause_ff;
      rsp_failed_in  = rsp_failed_ff;

      case (state_ff)
         ST_CLEAR: begin
            if (scan_ff == SCAN_W'(SCAN_ENTRIES - 1)) begin
               scan_in  = '0;
               state_in = ST_IDLE;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (q_valid) begin
               q_pop        = 1'b1;
               cur_in       = q_item;
               scan_in      = '0;
               a_found_in   = 1'b0; a_free_ok_in = 1'b0;
               l_found_in   = 1'b0; l_free_ok_in = 1'b0;
               r_found_in   = 1'b0; r_free_ok_in = 1'b0;
               c_found_in   = 1'b0; c_free_ok_in = 1'b0;
               res_verdict_in = 1'b0;
               res_failed_in  = 1'b0;
               if (q_item.op == OP_NOP) begin
                  res_cause_in = CAUSE_CONTROL;
                  state_in     = ST_DONE;
               end else if (q_item.op == OP_NOT_IPV4) begin
                  res_cause_in = CAUSE_NOT_IPV4;
                  state_in     = ST_DONE;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            sd_in   = scan_ff;
            live_in = scan_ff < SCAN_W'(SCAN_ENTRIES);
            if (scan_ff != SCAN_W'(SCAN_ENTRIES)) begin
               scan_in = scan_ff + 1'b1;
            end
            if (live_ff) begin
               if (sd_ff < SCAN_W'(ALLOW_ENTRIES)) begin
                  if (a_rd.valid && a_rd.key == cur_ff.ip && !a_found_ff) begin
                     a_found_in = 1'b1;
                     a_fidx_in  = sd_ff[ALLOW_AW-1:0];
                  end
                  if (!a_rd.valid && !a_free_ok_ff) begin
                     a_free_ok_in = 1'b1;
                     a_free_in    = sd_ff[ALLOW_AW-1:0];
                  end
               end
               if (sd_ff < SCAN_W'(LOG_BAN_ENTRIES)) begin
                  if (l_rd.valid && l_rd.key == cur_ff.ip && !l_found_ff) begin
                     l_found_in = 1'b1;
                     l_fidx_in  = sd_ff[LOG_AW-1:0];
                     l_exp_in   = l_rd.expiry;
                  end
                  if (!l_rd.valid && !l_free_ok_ff) begin
                     l_free_ok_in = 1'b1;
                     l_free_in    = sd_ff[LOG_AW-1:0];
                  end
               end
               if (sd_ff < SCAN_W'(RATE_BAN_ENTRIES)) begin
                  if (r_rd.valid && r_rd.key == cur_ff.ip && !r_found_ff) begin
                     r_found_in = 1'b1;
                     r_fidx_in  = sd_ff[RATE_AW-1:0];
                     r_exp_in   = r_rd.expiry;
                  end
                  if (!r_rd.valid && !r_free_ok_ff) begin
                     r_free_ok_in = 1'b1;
                     r_free_in    = sd_ff[RATE_AW-1:0];
                  end
               end
               if (sd_ff < SCAN_W'(COUNTER_ENTRIES)) begin
                  if (c_rd.valid && c_rd.key == cur_ff.ip && !c_found_ff) begin
                     c_found_in = 1'b1;
                     c_fidx_in  = sd_ff[COUNTER_AW-1:0];
                     c_start_in = c_rd.start;
                     c_count_in = c_rd.count;
                  end
                  if (!c_rd.valid && !c_free_ok_ff) begin
                     c_free_ok_in = 1'b1;
                     c_free_in    = sd_ff[COUNTER_AW-1:0];
                  end
               end
            end
            if (scan_ff == SCAN_W'(SCAN_ENTRIES)) begin
               state_in = ST_DEC1;
            end
         end
         ST_DEC1: begin
            l_live_in   = l_found_ff && (cur_ff.now < l_exp_ff);
            r_live_in   = r_found_ff && (cur_ff.now < r_exp_ff);
            in_win_in   = (cur_ff.now - c_start_ff) < cfg.window;
            cnt_next_in = (c_count_ff == COUNT_MAX) ? COUNT_MAX : c_count_ff + 1'b1;
            ban_exp_in  = cur_ff.now + cfg.ban;
            state_in    = ST_DEC2;
         end
         ST_DEC2: begin
            a_we_in  = 1'b0;
            l_we_in  = 1'b0;
            r_we_in  = 1'b0;
            r2_we_in = 1'b0;
            c_we_in  = 1'b0;
            res_verdict_in = 1'b0;
            res_failed_in  = 1'b0;
            res_cause_in   = CAUSE_CONTROL;
            case (cur_ff.op)
               OP_ALLOW_ADD: begin
                  if (!a_found_ff) begin
                     if (a_free_ok_ff) begin
                        a_we_in = 1'b1;
                        a_wa_in = a_free_ff;
                        a_wd_in = '{valid: 1'b1, key: cur_ff.ip};
                     end else begin
                        res_failed_in = 1'b1;
                     end
                  end
               end
               OP_ALLOW_DEL: begin
                  a_we_in = a_found_ff;
                  a_wa_in = a_fidx_ff;
                  a_wd_in = '0;
               end
               OP_LOG_SET: begin
                  l_wd_in = '{valid: 1'b1, key: cur_ff.ip, expiry: cur_ff.ban_end};
                  if (l_found_ff) begin
                     l_we_in = 1'b1;
                     l_wa_in = l_fidx_ff;
                  end else if (l_free_ok_ff) begin
                     l_we_in = 1'b1;
                     l_wa_in = l_free_ff;
                  end else begin
                     res_failed_in = 1'b1;
                  end
               end
               OP_LOG_CLR: begin
                  l_we_in = l_found_ff;
                  l_wa_in = l_fidx_ff;
                  l_wd_in = '0;
               end
               OP_PACKET: begin
                  if (a_found_ff) begin
                     res_cause_in = CAUSE_ALLOWED;
                  end else if (l_live_ff) begin
                     res_verdict_in = 1'b1;
                     res_cause_in   = CAUSE_LOG_BAN;
                  end else begin
                     l_we_in = l_found_ff;
                     l_wa_in = l_fidx_ff;
                     l_wd_in = '0;
                     if (cur_ff.ack_only) begin
                        res_cause_in = CAUSE_ACK_ONLY;
                     end else if (r_live_ff) begin
                        res_verdict_in = 1'b1;
                        res_cause_in   = CAUSE_RATE_BAN;
                     end else begin
                        r_we_in  = r_found_ff;
                        r_wa_in  = r_fidx_ff;
                        r_wd_in  = '0;
                        r2_wd_in = '{valid: 1'b1, key: cur_ff.ip, expiry: ban_exp_ff};
                        res_cause_in = CAUSE_COUNTED;
                        c_wa_in = c_fidx_ff;
                        if (c_found_ff) begin
                           c_we_in = 1'b1;
                           if (!in_win_ff) begin
                              c_wd_in = '{valid: 1'b1, key: cur_ff.ip, start: cur_ff.now,
                                          count: COUNT_W'(1)};
                           end else if (cnt_next_ff > {1'b0, cfg.threshold}) begin
                              c_wd_in        = '0;
                              res_verdict_in = 1'b1;
                              res_cause_in   = CAUSE_NEW_BAN;
                              if (r_found_ff && (!r_free_ok_ff || r_fidx_ff < r_free_ff)) begin
                                 r_wd_in = '{valid: 1'b1, key: cur_ff.ip, expiry: ban_exp_ff};
                              end else if (r_free_ok_ff) begin
                                 r2_we_in = 1'b1;
                                 r2_wa_in = r_free_ff;
                              end else begin
                                 res_failed_in = 1'b1;
                              end
                           end else begin
                              c_wd_in = '{valid: 1'b1, key: cur_ff.ip, start: c_start_ff,
                                          count: cnt_next_ff};
                           end
                        end else if (c_free_ok_ff) begin
                           c_we_in = 1'b1;
                           c_wa_in = c_free_ff;
                           c_wd_in = '{valid: 1'b1, key: cur_ff.ip, start: cur_ff.now,
                                       count: COUNT_W'(1)};
                        end else begin
                           res_failed_in = 1'b1;
                        end
                     end
                  end
               end
               default: begin
               end
            endcase
            state_in = ST_WR;
         end
         ST_WR: begin
            state_in = ST_WR2;
         end
         ST_WR2: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in   = 1'b1;
               rsp_verdict_in = res_verdict_ff;
               rsp_cause_in   = res_cause_ff;
               rsp_failed_in  = res_failed_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         scan_ff      <= '0;
         live_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         a_we_ff      <= 1'b0;
         l_we_ff      <= 1'b0;
         r_we_ff      <= 1'b0;
         r2_we_ff     <= 1'b0;
         c_we_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_ff      <= scan_in;
         live_ff      <= live_in;
         rsp_valid_ff <= rsp_valid_in;
         a_we_ff      <= a_we_in;
         l_we_ff      <= l_we_in;
         r_we_ff      <= r_we_in;
         r2_we_ff     <= r2_we_in;
         c_we_ff      <= c_we_in;
      end
   end

   always_ff @(posedge clock) begin
      sd_ff <= sd_in;
      cur_ff <= cur_in;
      a_found_ff <= a_found_in; a_free_ok_ff <= a_free_ok_in;
      a_fidx_ff  <= a_fidx_in;  a_free_ff    <= a_free_in;
      l_found_ff <= l_found_in; l_free_ok_ff <= l_free_ok_in;
      l_fidx_ff  <= l_fidx_in;  l_free_ff    <= l_free_in;  l_exp_ff <= l_exp_in;
      r_found_ff <= r_found_in; r_free_ok_ff <= r_free_ok_in;
      r_fidx_ff  <= r_fidx_in;  r_free_ff    <= r_free_in;  r_exp_ff <= r_exp_in;
      c_found_ff <= c_found_in; c_free_ok_ff <= c_free_ok_in;
      c_fidx_ff  <= c_fidx_in;  c_free_ff    <= c_free_in;
      c_start_ff <= c_start_in; c_count_ff   <= c_count_in;
      l_live_ff   <= l_live_in;
      r_live_ff   <= r_live_in;
      in_win_ff   <= in_win_in;
      cnt_next_ff <= cnt_next_in;
      ban_exp_ff  <= ban_exp_in;
      a_wa_ff <= a_wa_in; a_wd_ff <= a_wd_in;
      l_wa_ff <= l_wa_in; l_wd_ff <= l_wd_in;
      r_wa_ff <= r_wa_in; r_wd_ff <= r_wd_in;
      r2_wa_ff <= r2_wa_in; r2_wd_ff <= r2_wd_in;
      c_wa_ff <= c_wa_in; c_wd_ff <= c_wd_in;
      res_verdict_ff <= res_verdict_in;
      res_cause_ff   <= res_cause_in;
      res_failed_ff  <= res_failed_in;
      rsp_verdict_ff <= rsp_verdict_in;
      rsp_cause_ff   <= rsp_cause_in;
      rsp_failed_ff  <= rsp_failed_in;
   end

   assign status.clearing   = (state_ff == ST_CLEAR);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_verdict       = rsp_verdict_ff;
   assign rsp_cause         = rsp_cause_ff;
   assign rsp_insert_failed = rsp_failed_ff;

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the per-source rate limit filter core
// ----------------------------------------------------------------------------
// A table of directed words covers the kinds, the flag rules, expiry, updates
// in place and time wrap. After it come phases of random words under
// different threshold, window and ban settings. Each accepted word is run
// through a local model of the four tables, and each response word is compared
// with the oldest predicted verdict. Idle gaps appear on both sides.
// ----------------------------------------------------------------------------
module tb;
   import srlf_pkg::*;

   typedef struct {
      logic [2:0]  kind;
      logic [31:0] ip;
      logic        ipv4;
      logic        tcp_ok;
      logic        ack;
      logic        syn;
      logic [63:0] now;
      logic [63:0] ban_end;
      logic        known;
      logic        e_verdict;
      cause_type   e_cause;
      logic        e_failed;
   } word_type;

   typedef struct {
      logic      verdict;
      cause_type cause;
      logic      failed;
   } verdict_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        csr_wr_en = 0;
   logic [1:0]  csr_index = '0;
   logic [63:0] csr_wdata = '0;
   logic        req_valid = 0;
   logic        req_stall;
   logic [2:0]  req_kind = '0;
   logic [31:0] req_src_ip = '0;
   logic        req_is_ipv4 = 0;
   logic        req_tcp_header_ok = 0;
   logic        req_tcp_ack = 0;
   logic        req_tcp_syn = 0;
   logic [63:0] req_now_ns = '0;
   logic [63:0] req_ban_until_ns = '0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic        rsp_verdict;
   logic [2:0]  rsp_cause;
   logic        rsp_insert_failed;

   per_source_rate_limit_filter_core uut (.*);

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   // model state
   logic [15:0] m_threshold = THRESHOLD_RESET;
   logic [63:0] m_window = WINDOW_RESET;
   logic [63:0] m_ban = BAN_RESET;
   logic [31:0] al_key [ALLOW_ENTRIES];
   logic        al_vld [ALLOW_ENTRIES] = '{default: 1'b0};
   logic [31:0] lb_key [LOG_BAN_ENTRIES];
   logic [63:0] lb_exp [LOG_BAN_ENTRIES];
   logic        lb_vld [LOG_BAN_ENTRIES] = '{default: 1'b0};
   logic [31:0] rb_key [RATE_BAN_ENTRIES];
   logic [63:0] rb_exp [RATE_BAN_ENTRIES];
   logic        rb_vld [RATE_BAN_ENTRIES] = '{default: 1'b0};
   logic [31:0] ct_key [COUNTER_ENTRIES];
   logic [63:0] ct_start [COUNTER_ENTRIES];
   logic [COUNT_W-1:0] ct_count [COUNTER_ENTRIES];
   logic        ct_vld [COUNTER_ENTRIES] = '{default: 1'b0};

   word_type    feed_q [$];
   verdict_type verdict_q [$];
   word_type    cur;
   int          errors = 0;
   int          n_words = 0;
   int          n_checked = 0;
   int          n_drops = 0;
   int          n_new_bans = 0;
   int          gap_left = 0;
   int          stall_left = 0;
   bit          no_idle = 0;
   logic [63:0] clock_ns = 64'd0;
   logic [31:0] ip_pool [6];

   function automatic int find_allow(logic [31:0] k);
      for (int i = 0; i < ALLOW_ENTRIES; i++)
         if (al_vld[i] && al_key[i] == k) return i;
      return -1;
   endfunction

   function automatic int find_log(logic [31:0] k);
      for (int i = 0; i < LOG_BAN_ENTRIES; i++)
         if (lb_vld[i] && lb_key[i] == k) return i;
      return -1;
   endfunction

   function automatic int find_rate(logic [31:0] k);
      for (int i = 0; i < RATE_BAN_ENTRIES; i++)
         if (rb_vld[i] && rb_key[i] == k) return i;
      return -1;
   endfunction

   function automatic int find_ctr(logic [31:0] k);
      for (int i = 0; i < COUNTER_ENTRIES; i++)
         if (ct_vld[i] && ct_key[i] == k) return i;
      return -1;
   endfunction

   // runs one word through the table model and gives its verdict
   function automatic verdict_type filter_word(word_type w);
      verdict_type r;
      int i;
      int b;
      r = '{1'b0, CAUSE_CONTROL, 1'b0};
      case (w.kind)
         KIND_ALLOW_ADD: begin
            if (find_allow(w.ip) < 0) begin
               i = -1;
               for (int j = 0; j < ALLOW_ENTRIES && i < 0; j++)
                  if (!al_vld[j]) i = j;
               if (i < 0) r.failed = 1;
               else begin
                  al_vld[i] = 1;
                  al_key[i] = w.ip;
               end
            end
            return r;
         end
         KIND_ALLOW_DEL: begin
            i = find_allow(w.ip);
            if (i >= 0) al_vld[i] = 0;
            return r;
         end
         KIND_LOG_SET: begin
            i = find_log(w.ip);
            if (i < 0) begin
               for (int j = 0; j < LOG_BAN_ENTRIES && i < 0; j++)
                  if (!lb_vld[j]) i = j;
               if (i >= 0) begin
                  lb_vld[i] = 1;
                  lb_key[i] = w.ip;
               end
            end
            if (i < 0) r.failed = 1;
            else lb_exp[i] = w.ban_end;
            return r;
         end
         KIND_LOG_CLR: begin
            i = find_log(w.ip);
            if (i >= 0) lb_vld[i] = 0;
            return r;
         end
         KIND_PACKET: ;
         default: return r;
      endcase
      r.verdict = 0;
      if (!w.ipv4) begin
         r.cause = CAUSE_NOT_IPV4;
         return r;
      end
      if (find_allow(w.ip) >= 0) begin
         r.cause = CAUSE_ALLOWED;
         return r;
      end
      i = find_log(w.ip);
      if (i >= 0) begin
         if (w.now < lb_exp[i]) begin
            r = '{1'b1, CAUSE_LOG_BAN, 1'b0};
            return r;
         end
         lb_vld[i] = 0;
      end
      if (w.tcp_ok && w.ack && !w.syn) begin
         r.cause = CAUSE_ACK_ONLY;
         return r;
      end
      i = find_rate(w.ip);
      if (i >= 0) begin
         if (w.now < rb_exp[i]) begin
            r = '{1'b1, CAUSE_RATE_BAN, 1'b0};
            return r;
         end
         rb_vld[i] = 0;
      end
      r.cause = CAUSE_COUNTED;
      i = find_ctr(w.ip);
      if (i >= 0) begin
         if (w.now - ct_start[i] < m_window) begin
            if (ct_count[i] != COUNT_MAX) ct_count[i]++;
            if (ct_count[i] > m_threshold) begin
               ct_vld[i] = 0;
               r = '{1'b1, CAUSE_NEW_BAN, 1'b0};
               b = find_rate(w.ip);
               if (b < 0) begin
                  for (int j = 0; j < RATE_BAN_ENTRIES && b < 0; j++)
                     if (!rb_vld[j]) b = j;
                  if (b >= 0) begin
                     rb_vld[b] = 1;
                     rb_key[b] = w.ip;
                  end
               end
               if (b < 0) r.failed = 1;
               else rb_exp[b] = w.now + m_ban;
            end
         end else begin
            ct_start[i] = w.now;
            ct_count[i] = 1;
         end
         return r;
      end
      for (int j = 0; j < COUNTER_ENTRIES && i < 0; j++)
         if (!ct_vld[j]) i = j;
      if (i < 0) r.failed = 1;
      else begin
         ct_vld[i] = 1;
         ct_key[i] = w.ip;
         ct_start[i] = w.now;
         ct_count[i] = 1;
      end
      return r;
   endfunction

   function automatic word_type row(logic [2:0] k, logic [31:0] ip, logic [3:0] fl,
                                    logic [63:0] now, logic [63:0] bu, logic known,
                                    logic v, cause_type c);
      word_type w;
      w = '{k, ip, fl[3], fl[2], fl[1], fl[0], now, bu, known, v, c, 1'b0};
      return w;
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (no_idle || r < 55) return 0;
      if (r < 90) return $urandom_range(3, 1);
      return $urandom_range(60, 8);
   endfunction

   // mostly well-formed packets from a few sources with advancing time
   function automatic word_type random_word();
      word_type w;
      int r;
      r = $urandom_range(99);
      w.known = 0;
      w.e_verdict = 0;
      w.e_cause = CAUSE_CONTROL;
      w.e_failed = 0;
      w.ip = ($urandom_range(19) == 0) ? $urandom : ip_pool[$urandom_range(5)];
      w.ipv4 = ($urandom_range(9) != 0);
      w.tcp_ok = $urandom_range(1);
      w.ack = $urandom_range(3) == 0;
      w.syn = $urandom_range(1);
      if ($urandom_range(29) == 0) w.now = rand64();
      else begin
         clock_ns = clock_ns + $urandom_range(3000);
         w.now = clock_ns;
      end
      w.ban_end = ($urandom_range(9) == 0) ? rand64() : clock_ns + $urandom_range(20000);
      if (r < 72) w.kind = KIND_PACKET;
      else if (r < 79) w.kind = KIND_ALLOW_ADD;
      else if (r < 85) w.kind = KIND_ALLOW_DEL;
      else if (r < 92) w.kind = KIND_LOG_SET;
      else if (r < 97) w.kind = KIND_LOG_CLR;
      else w.kind = 3'($urandom_range(7, 5));
      return w;
   endfunction

   task automatic write_reg(logic [1:0] idx, logic [63:0] val);
      @(posedge clock);
      csr_wr_en <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         REG_THRESHOLD: m_threshold = val[15:0];
         REG_WINDOW:    m_window = val;
         REG_BAN:       m_ban = val;
         default: ;
      endcase
      @(posedge clock);
      csr_wr_en <= 0;
   endtask

   task automatic drain();
      while (feed_q.size() != 0 || req_valid || verdict_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch on word %0d: %s got %0d expected %0d", n_checked, what, got, want);
      errors++;
   endtask

   // request side
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            verdict_type v;
            v = filter_word(cur);
            if (cur.known) v = '{cur.e_verdict, cur.e_cause, cur.e_failed};
            verdict_q.push_back(v);
            n_words++;
         end
         if (req_valid && req_stall) begin
            // hold the word
         end else if (gap_left > 0) begin
            gap_left--;
            req_valid <= 0;
         end else if (feed_q.size() != 0) begin
            cur = feed_q.pop_front();
            req_valid <= 1;
            req_kind <= cur.kind;
            req_src_ip <= cur.ip;
            req_is_ipv4 <= cur.ipv4;
            req_tcp_header_ok <= cur.tcp_ok;
            req_tcp_ack <= cur.ack;
            req_tcp_syn <= cur.syn;
            req_now_ns <= cur.now;
            req_ban_until_ns <= cur.ban_end;
            gap_left = pick_gap();
         end else begin
            req_valid <= 0;
         end
      end
   end

   // response side
   always @(posedge clock) begin
      if (rsp_valid && !rsp_stall) begin
         if (verdict_q.size() == 0) begin
            $display("response word with nothing outstanding");
            errors++;
         end else begin
            verdict_type v;
            v = verdict_q.pop_front();
            if (rsp_verdict !== v.verdict) report_mismatch("verdict", rsp_verdict, v.verdict);
            if (rsp_cause !== v.cause) report_mismatch("cause", rsp_cause, v.cause);
            if (rsp_insert_failed !== v.failed)
               report_mismatch("insert_failed", rsp_insert_failed, v.failed);
            if (rsp_verdict) n_drops++;
            if (rsp_cause == CAUSE_NEW_BAN) n_new_bans++;
            n_checked++;
         end
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1;
      end else begin
         rsp_stall <= 0;
         if (!no_idle && $urandom_range(99) < 15)
            stall_left = ($urandom_range(9) == 0) ? $urandom_range(200, 20)
                                                  : $urandom_range(3, 1);
      end
   end

   initial begin
      #40000000;
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      word_type dir [$];
      logic [63:0] cfg [4][3];
      for (int i = 0; i < 6; i++) ip_pool[i] = $urandom;
      cfg = '{'{64'd1, '1, 64'd0},
              '{64'd3, 64'd5000, 64'd3000},
              '{64'd65535, 64'd1, '1},
              '{64'd2, 64'd20000, 64'd40000}};
      dir = '{
         row(KIND_PACKET, 32'h0A000001, 4'b0000, 64'd5, 64'd0, 1, 0, CAUSE_NOT_IPV4),
         row(3'd5, 32'h0A000001, 4'b1111, 64'd5, 64'd0, 1, 0, CAUSE_CONTROL),
         row(3'd7, '1, 4'b1000, '1, '1, 1, 0, CAUSE_CONTROL),
         row(KIND_ALLOW_ADD, '1, 4'b1000, 64'd0, 64'd0, 1, 0, CAUSE_CONTROL),
         row(KIND_ALLOW_ADD, '1, 4'b1000, 64'd0, 64'd0, 1, 0, CAUSE_CONTROL),
         row(KIND_PACKET, '1, 4'b1111, '1, 64'd0, 1, 0, CAUSE_ALLOWED),
         row(KIND_ALLOW_DEL, '1, 4'b0000, 64'd0, 64'd0, 1, 0, CAUSE_CONTROL),
         row(KIND_ALLOW_DEL, 32'd0, 4'b0000, 64'd0, 64'd0, 1, 0, CAUSE_CONTROL),
         row(KIND_PACKET, '1, 4'b1000, 64'd7, 64'd0, 0, 0, CAUSE_CONTROL),
         row(KIND_LOG_SET, 32'd0, 4'b0000, 64'd0, 64'd1000, 1, 0, CAUSE_CONTROL),
         row(KIND_LOG_SET, 32'd0, 4'b0000, 64'd0, 64'd2000, 1, 0, CAUSE_CONTROL),
         row(KIND_PACKET, 32'd0, 4'b1000, 64'd1500, 64'd0, 1, 1, CAUSE_LOG_BAN),
         row(KIND_PACKET, 32'd0, 4'b1110, 64'd2000, 64'd0, 1, 0, CAUSE_ACK_ONLY),
         row(KIND_LOG_CLR, 32'd0, 4'b0000, 64'd0, 64'd0, 1, 0, CAUSE_CONTROL),
         row(KIND_LOG_SET, 32'd9, 4'b0000, 64'd0, '1, 1, 0, CAUSE_CONTROL),
         row(KIND_PACKET, 32'd9, 4'b1000, 64'hFFFF_FFFF_FFFF_FFFE, 64'd0, 1, 1,
             CAUSE_LOG_BAN),
         row(KIND_LOG_CLR, 32'd9, 4'b0000, 64'd0, 64'd0, 1, 0, CAUSE_CONTROL),
         row(KIND_PACKET, 32'd1, 4'b1111, 64'd0, 64'd0, 0, 0, CAUSE_CONTROL),
         row(KIND_PACKET, 32'd1, 4'b1010, 64'd10, 64'd0, 0, 0, CAUSE_CONTROL),
         row(KIND_PACKET, 32'd1, 4'b1100, 64'd20, 64'd0, 0, 0, CAUSE_CONTROL),
         row(KIND_PACKET, 32'd2, 4'b1000, '1, 64'd0, 0, 0, CAUSE_CONTROL),
         row(KIND_PACKET, 32'd2, 4'b1000, 64'd0, 64'd0, 0, 0, CAUSE_CONTROL),
         row(KIND_PACKET, 32'd2, 4'b1000, 64'd1000000000, 64'd0, 0, 0, CAUSE_CONTROL)
      };
      repeat (3) @(posedge clock);
      reset <= 0;
      foreach (dir[i]) feed_q.push_back(dir[i]);
      drain();
      for (int p = 0; p < 4; p++) begin
         write_reg(REG_THRESHOLD, cfg[p][0]);
         write_reg(REG_WINDOW, cfg[p][1]);
         write_reg(REG_BAN, cfg[p][2]);
         no_idle = (p == 1);
         for (int n = 0; n < 107; n++) feed_q.push_back(random_word());
         drain();
      end
      $display("%0d words sent, %0d responses checked under 5 register settings",
               n_words, n_checked);
      $display("%0d drops seen, %0d of them new rate bans", n_drops, n_new_bans);
      if (errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// ----- per_source_rate_limit_filter_core.f -----
rtl/srlf_pkg.sv
rtl/srlf_ram.sv
rtl/srlf_front.sv
rtl/srlf_fifo.sv
rtl/srlf_back.sv
rtl/per_source_rate_limit_filter_core.sv
tb/tb.sv
